// ----- hw/rtl/m3i_pkg.sv -----
// m3i_pkg: widths, types and latency of the 3x3 fixed-point matrix inverse.
// Used by m3i_div and matrix3_inverse; depends on nothing.
`default_nettype none
package m3i_pkg;
   localparam int DIM       = 3;
   localparam int FRAC_BITS = 16;
   localparam int EW        = 32;                  // element width
   localparam int PW        = 2 * EW;              // product / cofactor width
   localparam int DW        = PW + EW + 2;         // determinant width
   localparam int QW        = EW + 1;              // quotient bits kept
   localparam int NW        = PW + 2 * FRAC_BITS;  // dividend width
   localparam int PRE_STG   = 5;                   // stages ahead of the dividers
   localparam int LAT       = PRE_STG + QW + 2;    // start to strobe, in cycles

   typedef logic signed [EW-1:0] elem_type;
   typedef logic signed [PW-1:0] prod_type;
   typedef logic signed [DW-1:0] det_type;

   typedef struct packed {
      logic valid;
      logic neg;
      logic sing;
   } side_type;
endpackage
`default_nettype wire

// ----- hw/rtl/m3i_div.sv -----
// m3i_div: fully pipelined restoring divider, one quotient bit per stage.
// Depends on m3i_pkg for widths and the sideband struct.
`default_nettype none
module m3i_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire m3i_pkg::side_type           in_side,
   input  wire logic [m3i_pkg::NW-1:0]      in_num,
   input  wire logic [m3i_pkg::DW-1:0]      in_den,
   output m3i_pkg::side_type                out_side,
   output logic      [m3i_pkg::QW-1:0]      out_q,
   output logic                             out_ovf
);
   localparam int QW = m3i_pkg::QW;
   localparam int DW = m3i_pkg::DW;
   localparam int NW = m3i_pkg::NW;

   m3i_pkg::side_type side_ff [0:QW];
   logic [DW-1:0]     rem_ff  [0:QW];
   logic [DW-1:0]     den_ff  [0:QW];
   logic [QW-1:0]     lo_ff   [0:QW];
   logic [QW-1:0]     q_ff    [0:QW];
   logic              ovf_ff  [0:QW];

   logic [DW-1:0] rem0_in;
   assign rem0_in = {{(DW-(NW-QW)){1'b0}}, in_num[NW-1:QW]};

   // head stage: high part of the dividend; overflow when it already reaches the divisor
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0].valid <= 1'b0;
      end else begin
         side_ff[0] <= in_side;
      end
      rem_ff[0] <= rem0_in;
      den_ff[0] <= in_den;
      lo_ff[0]  <= in_num[QW-1:0];
      q_ff[0]   <= '0;
      ovf_ff[0] <= (rem0_in >= in_den);
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      logic [DW-1:0] trial;
      logic          ge;
      assign trial = {rem_ff[k-1][DW-2:0], lo_ff[k-1][QW-1]};
      assign ge    = (trial >= den_ff[k-1]);
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k].valid <= 1'b0;
         end else begin
            side_ff[k] <= side_ff[k-1];
         end
         rem_ff[k] <= ge ? trial - den_ff[k-1] : trial;
         den_ff[k] <= den_ff[k-1];
         lo_ff[k]  <= {lo_ff[k-1][QW-2:0], 1'b0};
         q_ff[k]   <= {q_ff[k-1][QW-2:0], ge};
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign out_side = side_ff[QW];
   assign out_q    = q_ff[QW];
   assign out_ovf  = ovf_ff[QW];
endmodule
`default_nettype wire

// ----- hw/rtl/matrix3_inverse.sv -----
// matrix3_inverse: 3x3 Q16.16 matrix inverse by adjugate over determinant.
// Depends on m3i_pkg and nine m3i_div lanes.
//
//   channel  | handshake           | payload
//   request  | start && !busy      | req_a00 .. req_a22
//   response | rsp_valid (strobe)  | rsp_b00 .. rsp_b22, rsp_singular, rsp_saturated
//
// One matrix enters every cycle; busy stays low.
// The path runs through five cofactor/determinant stages,
// a 34-stage divider per element (a head stage, then one quotient bit a stage), one output stage.
// Synchronous reset clears all valid bits; data in flight is dropped.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module matrix3_inverse (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [31:0]        req_a00,
   input  wire logic signed [31:0]        req_a01,
   input  wire logic signed [31:0]        req_a02,
   input  wire logic signed [31:0]        req_a10,
   input  wire logic signed [31:0]        req_a11,
   input  wire logic signed [31:0]        req_a12,
   input  wire logic signed [31:0]        req_a20,
   input  wire logic signed [31:0]        req_a21,
   input  wire logic signed [31:0]        req_a22,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_b00,
   output logic signed [31:0]             rsp_b01,
   output logic signed [31:0]             rsp_b02,
   output logic signed [31:0]             rsp_b10,
   output logic signed [31:0]             rsp_b11,
   output logic signed [31:0]             rsp_b12,
   output logic signed [31:0]             rsp_b20,
   output logic signed [31:0]             rsp_b21,
   output logic signed [31:0]             rsp_b22,
   output logic                           rsp_singular,
   output logic                           rsp_saturated
);
   localparam int DIM = m3i_pkg::DIM;
   localparam int EW  = m3i_pkg::EW;
   localparam int PW  = m3i_pkg::PW;
   localparam int DW  = m3i_pkg::DW;
   localparam int QW  = m3i_pkg::QW;
   localparam int FB2 = 2 * m3i_pkg::FRAC_BITS;
   localparam int NE  = DIM * DIM;

   m3i_pkg::elem_type m_w [0:DIM-1][0:DIM-1];
   assign m_w[0][0] = req_a00;  assign m_w[0][1] = req_a01;  assign m_w[0][2] = req_a02;
   assign m_w[1][0] = req_a10;  assign m_w[1][1] = req_a11;  assign m_w[1][2] = req_a12;
   assign m_w[2][0] = req_a20;  assign m_w[2][1] = req_a21;  assign m_w[2][2] = req_a22;

   assign busy = 1'b0;

   logic [m3i_pkg::PRE_STG-1:0] v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[m3i_pkg::PRE_STG-2:0], start & ~busy};
      end
   end

   // stage A: cofactor products; stage B: cofactors
   m3i_pkg::prod_type pa_ff  [0:DIM-1][0:DIM-1];
   m3i_pkg::prod_type pb_ff  [0:DIM-1][0:DIM-1];
   m3i_pkg::prod_type cofb_ff[0:DIM-1][0:DIM-1];
   m3i_pkg::prod_type cofc_ff[0:DIM-1][0:DIM-1];
   m3i_pkg::prod_type cofd_ff[0:DIM-1][0:DIM-1];
   m3i_pkg::elem_type rowa_ff[0:DIM-1];
   m3i_pkg::elem_type rowb_ff[0:DIM-1];

   for (genvar i = 0; i < DIM; i++) begin : g_ci
      for (genvar j = 0; j < DIM; j++) begin : g_cj
         localparam int R1 = (j + 1) % DIM;
         localparam int R2 = (j + 2) % DIM;
         localparam int C1 = (i + 1) % DIM;
         localparam int C2 = (i + 2) % DIM;
         always_ff @(posedge clock) begin
            pa_ff[i][j]   <= m_w[R1][C1] * m_w[R2][C2];
            pb_ff[i][j]   <= m_w[R1][C2] * m_w[R2][C1];
            cofb_ff[i][j] <= pa_ff[i][j] - pb_ff[i][j];
            cofc_ff[i][j] <= cofb_ff[i][j];
            cofd_ff[i][j] <= cofc_ff[i][j];
         end
      end
   end

   // stage C: row-0 expansion, cofactor split into signed high and unsigned low halves
   logic signed [PW-1:0] ph_ff [0:DIM-1];
   logic signed [PW:0]   pl_ff [0:DIM-1];
   logic [DW-1:0]        term_w[0:DIM-1];

   for (genvar k = 0; k < DIM; k++) begin : g_det
      logic signed [EW-1:0] hi_w;
      logic signed [EW:0]   lo_w;
      assign hi_w = cofb_ff[k][0][PW-1:EW];
      assign lo_w = {1'b0, cofb_ff[k][0][EW-1:0]};
      always_ff @(posedge clock) begin
         rowa_ff[k] <= m_w[0][k];
         rowb_ff[k] <= rowa_ff[k];
         ph_ff[k]   <= rowb_ff[k] * hi_w;
         pl_ff[k]   <= rowb_ff[k] * lo_w;
      end
      assign term_w[k] = ({{(DW-PW){ph_ff[k][PW-1]}}, ph_ff[k]} << EW)
                       + {{(DW-PW-1){pl_ff[k][PW]}}, pl_ff[k]};
   end

   // stage D: determinant
   logic [DW-1:0] det_ff;
   always_ff @(posedge clock) begin
      det_ff <= term_w[0] + term_w[1] + term_w[2];
   end

   // stage E: magnitudes and signs
   logic [DW-1:0]     dmag_ff;
   logic              sing_ff;
   logic [PW-1:0]     cmag_ff [0:NE-1];
   logic              neg_ff  [0:NE-1];

   always_ff @(posedge clock) begin
      dmag_ff <= det_ff[DW-1] ? -det_ff : det_ff;
      sing_ff <= (det_ff == '0);
   end

   m3i_pkg::side_type side_out_w [0:NE-1];
   logic [QW-1:0]     q_w        [0:NE-1];
   logic              ovf_w      [0:NE-1];
   logic [EW-1:0]     val_w      [0:NE-1];
   logic [NE-1:0]     sat_w;

   for (genvar e = 0; e < NE; e++) begin : g_lane
      m3i_pkg::side_type side_in_w;
      logic              big_w;
      always_ff @(posedge clock) begin
         cmag_ff[e] <= cofd_ff[e/DIM][e%DIM][PW-1] ? -cofd_ff[e/DIM][e%DIM]
                                                   : cofd_ff[e/DIM][e%DIM];
         neg_ff[e]  <= cofd_ff[e/DIM][e%DIM][PW-1] ^ det_ff[DW-1];
      end
      assign side_in_w.valid = v_ff[m3i_pkg::PRE_STG-1];
      assign side_in_w.neg   = neg_ff[e];
      assign side_in_w.sing  = sing_ff;

      m3i_div u_div (
         .clock    (clock),
         .reset    (reset),
         .in_side  (side_in_w),
         .in_num   ({cmag_ff[e], {FB2{1'b0}}}),
         .in_den   (dmag_ff),
         .out_side (side_out_w[e]),
         .out_q    (q_w[e]),
         .out_ovf  (ovf_w[e])
      );

      // clamp: positive past 2^31-1, negative past 2^31
      assign big_w = side_out_w[e].neg
                   ? (ovf_w[e] | q_w[e][QW-1]
                      | (q_w[e][QW-2] & (q_w[e][QW-3:0] != '0)))
                   : (ovf_w[e] | q_w[e][QW-1] | q_w[e][QW-2]);
      always_comb begin
         sat_w[e] = 1'b0;
         if (side_out_w[e].sing) begin
            val_w[e] = '0;
         end else if (big_w) begin
            sat_w[e] = 1'b1;
            val_w[e] = side_out_w[e].neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
         end else begin
            val_w[e] = side_out_w[e].neg ? -q_w[e][EW-1:0] : q_w[e][EW-1:0];
         end
      end
   end

   // output stage
   logic          rv_ff;
   logic [EW-1:0] b_ff [0:NE-1];
   logic          sing_out_ff;
   logic          sat_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= side_out_w[0].valid;
      end
      b_ff        <= val_w;
      sing_out_ff <= side_out_w[0].sing;
      sat_out_ff  <= |sat_w;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_b00       = b_ff[0];
   assign rsp_b01       = b_ff[1];
   assign rsp_b02       = b_ff[2];
   assign rsp_b10       = b_ff[3];
   assign rsp_b11       = b_ff[4];
   assign rsp_b12       = b_ff[5];
   assign rsp_b20       = b_ff[6];
   assign rsp_b21       = b_ff[7];
   assign rsp_b22       = b_ff[8];
   assign rsp_singular  = sing_out_ff;
   assign rsp_saturated = sat_out_ff;

   // a singular result carries no clamp and zero elements b00, b11, b22 and b02
   a_sing_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> !rsp_saturated && rsp_b00 == 0 && rsp_b11 == 0
                                    && rsp_b22 == 0 && rsp_b02 == 0)
      else $error("singular result not clean");

   // every strobe traces back to an earlier transfer
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, m3i_pkg::LAT))
      else $error("result without matching request");

   // lanes 0, 4 and 8 stay in lock step
   a_lanes : assert property (@(posedge clock) disable iff (reset)
      side_out_w[0].valid == side_out_w[8].valid
      && (!side_out_w[0].valid || side_out_w[0].sing == side_out_w[4].sing))
      else $error("divider lanes out of step");
endmodule
`default_nettype wire

// ----- verif/matrix3_inverse_tb.sv -----
// matrix3_inverse_tb: self-checking bench for the 3x3 Q16.16 adjugate inverse.
// Depends on m3i_pkg and matrix3_inverse; a scoreboard class predicts each result.
`default_nettype none

class inverse_scoreboard;
   typedef struct {
      logic signed [31:0] b[9];
      logic               sing;
      logic               sat;
   } inv_result;

   inv_result pending[$];
   int        mismatches;
   int        checked;
   int        n_sing;
   int        n_sat;

   // Exact adjugate over determinant, truncated toward zero, clamped.
   function void note_matrix(logic signed [31:0] a[9]);
      logic signed [63:0]  cof[3][3];
      logic signed [127:0] det, num, q;
      inv_result           r;
      int                  r1, r2, c1, c2;
      det = 0;
      r.sing = 0;
      r.sat  = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            r1 = (j + 1) % 3; r2 = (j + 2) % 3;
            c1 = (i + 1) % 3; c2 = (i + 2) % 3;
            cof[i][j] = 64'(a[r1*3+c1]) * 64'(a[r2*3+c2])
                      - 64'(a[r1*3+c2]) * 64'(a[r2*3+c1]);
         end
      for (int k = 0; k < 3; k++)
         det += 128'(a[k]) * 128'(cof[k][0]);
      if (det == 0) begin
         r.sing = 1;
         foreach (r.b[k]) r.b[k] = 0;
      end else begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               num = 128'(cof[i][j]) <<< (2 * m3i_pkg::FRAC_BITS);
               q   = num / det;  // signed division truncates toward zero
               if (q > 128'sh7FFFFFFF) begin
                  r.b[i*3+j] = 32'h7FFFFFFF; r.sat = 1;
               end else if (q < -128'sh80000000) begin
                  r.b[i*3+j] = 32'h80000000; r.sat = 1;
               end else
                  r.b[i*3+j] = q[31:0];
            end
      end
      pending.push_back(r);
   endfunction

   function void check_result(logic signed [31:0] b[9], logic sing, logic sat);
      inv_result e;
      if (pending.size() == 0) begin
         report("result with nothing pending", 0, 0);
         return;
      end
      e = pending.pop_front();
      checked++;
      n_sing += e.sing;
      n_sat  += e.sat;
      for (int k = 0; k < 9; k++)
         if (b[k] !== e.b[k]) report($sformatf("b%0d%0d", k / 3, k % 3), b[k], e.b[k]);
      if (sing !== e.sing) report("singular", sing, e.sing);
      if (sat !== e.sat) report("saturated", sat, e.sat);
   endfunction

   function void report(string what, longint got, longint want);
      mismatches++;
      if (mismatches <= 50)
         $display("MISMATCH %s: got %0h expected %0h", what, got, want);
   endfunction
endclass

module matrix3_inverse_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM = 1150;
   localparam int LIMIT      = 200000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [31:0] req_a[9];
   logic rsp_valid, rsp_singular, rsp_saturated;
   logic signed [31:0] rsp_b[9];
   int   cycles = 0;
   inverse_scoreboard sb = new();

   initial foreach (req_a[k]) req_a[k] = 0;

   always #2 clock = ~clock;

   matrix3_inverse DUT (
      .clock, .reset, .start, .busy,
      .req_a00(req_a[0]), .req_a01(req_a[1]), .req_a02(req_a[2]),
      .req_a10(req_a[3]), .req_a11(req_a[4]), .req_a12(req_a[5]),
      .req_a20(req_a[6]), .req_a21(req_a[7]), .req_a22(req_a[8]),
      .rsp_valid,
      .rsp_b00(rsp_b[0]), .rsp_b01(rsp_b[1]), .rsp_b02(rsp_b[2]),
      .rsp_b10(rsp_b[3]), .rsp_b11(rsp_b[4]), .rsp_b12(rsp_b[5]),
      .rsp_b20(rsp_b[6]), .rsp_b21(rsp_b[7]), .rsp_b22(rsp_b[8]),
      .rsp_singular, .rsp_saturated
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) sb.check_result(rsp_b, rsp_singular, rsp_saturated);
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Hold start until the transfer completes; lower it only when a gap follows.
   task automatic send_matrix(logic signed [31:0] m[9], int gap);
      start <= 1;
      foreach (m[k]) req_a[k] <= m[k];
      do @(posedge clock); while (busy);
      sb.note_matrix(m);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] rand_elem(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed(32'($urandom_range(0, 32'h3FFFF))) - 32'sh20000;
         2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed(32'($urandom_range(0, 16))) - 8;
      endcase
   endfunction

   logic signed [31:0] m[9];
   int mode, gap, burst;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: identity, scaled identity, zero, all extremes, singular rows,
      // tiny determinant (saturation), negative determinant, one-ulp elements.
      foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh10000 : 0;
      send_matrix(m, 0);
      foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh20000 : 0;
      send_matrix(m, 1);
      foreach (m[k]) m[k] = 0;
      send_matrix(m, 0);
      foreach (m[k]) m[k] = 32'sh7FFFFFFF;
      send_matrix(m, 2);
      foreach (m[k]) m[k] = 32'sh80000000;
      send_matrix(m, 0);
      foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh80000000 : 0;
      send_matrix(m, 0);
      foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh7FFFFFFF : 0;
      send_matrix(m, 0);
      foreach (m[k]) m[k] = (k % 4 == 0) ? 32'sh1 : 0;
      send_matrix(m, 0);
      foreach (m[k]) m[k] = (k % 4 == 0) ? -32'sh1 : 0;
      send_matrix(m, 3);
      foreach (m[k]) m[k] = (k % 4 == 0) ? -32'sh10000 : 0;
      send_matrix(m, 0);
      m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
            32'sh60000, 32'sh70000, 32'sh80000, 32'sh90000};
      send_matrix(m, 0);
      m = '{32'sh10000, 0, 0, 0, 0, 32'sh10000, 0, 32'sh10000, 0};
      send_matrix(m, 0);
      m = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
            32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh1};
      send_matrix(m, 0);
      m = '{32'sh2, 32'sh1, 0, 32'sh1, 32'sh2, 32'sh1, 0, 32'sh1, 32'sh2};
      send_matrix(m, 0);
      m = '{32'sh30000, -32'sh10000, 32'sh8000, 32'sh4000, 32'sh20000,
            -32'sh18000, 32'sh1000, 32'sh7000, -32'sh50000};
      send_matrix(m, 1);

      // Random: mixed magnitudes, bursts with no gaps, occasional duplicated rows.
      burst = 0;
      for (int n = 0; n < NUM_RANDOM; n++) begin
         mode = $urandom_range(0, 3);
         foreach (m[k]) m[k] = rand_elem($urandom_range(0, 7) == 0 ? 2 : mode);
         if ($urandom_range(0, 9) == 0)
            for (int c = 0; c < 3; c++) m[6+c] = m[3+c];
         if (burst > 0) begin
            burst--;
            gap = 0;
         end else begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 7) == 0) burst = $urandom_range(10, 40);
         end
         send_matrix(m, gap);
      end
      start <= 0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (m3i_pkg::LAT + 10) @(posedge clock);

      $display("covered %0d matrices: %0d singular, %0d saturated",
               sb.checked, sb.n_sing, sb.n_sat);
      if (sb.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
